### hdl/edf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// EDF scheduler package
// Shared types, constants and codes of the deadline scheduler.
// ----------------------------------------------------------------------------
package edf_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;
    localparam int REL_W           = 30;
    localparam int KEY_W           = 31;
    localparam int CLK_W           = 31;
    localparam int CNT_W           = 16;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_CREATE = 2'd1;
    localparam logic [1:0] MODE_YIELD  = 2'd2;
    localparam logic [1:0] MODE_FINISH = 2'd3;

    localparam logic [2:0] ST_NONE  = 3'd0;
    localparam logic [2:0] ST_SEL   = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SELECT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic select;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       full;
        logic       pending;
    } t_stat;

endpackage
`default_nettype wire

### hdl/edf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// EDF scheduler controller
// Sequences the step and select phases of one item and the output handshake.
// ----------------------------------------------------------------------------
module edf_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  wire              i_stall,
    input  edf_pkg::t_stat   i_st,
    output edf_pkg::t_cmd    o_cmd
);

    edf_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= edf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            edf_pkg::S_IDLE: begin
                if (i_valid) n_state = edf_pkg::S_SELECT;
            end
            edf_pkg::S_SELECT: n_state = edf_pkg::S_OUT;
            edf_pkg::S_OUT: begin
                if (!i_stall) n_state = i_valid ? edf_pkg::S_SELECT : edf_pkg::S_IDLE;
            end
            default: n_state = edf_pkg::S_IDLE;
        endcase
    end

    logic take;

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        take    = 1'b0;
        unique case (r_state)
            edf_pkg::S_IDLE: begin
                o_stall = 1'b0;
                take    = i_valid;
            end
            edf_pkg::S_SELECT: begin
                o_cmd.step = 1'b1;
            end
            edf_pkg::S_OUT: begin
                o_valid = 1'b1;
                o_stall = i_stall;
                take    = i_valid && !i_stall;
            end
            default: ;
        endcase
        o_cmd.load = take;
        o_cmd.emit = (r_state == edf_pkg::S_SELECT);
        o_cmd.select = (r_state == edf_pkg::S_SELECT) && !i_st.full && (
            (i_st.mode == edf_pkg::MODE_TICK && i_st.pending) ||
            i_st.mode == edf_pkg::MODE_YIELD || i_st.mode == edf_pkg::MODE_FINISH);
    end

    a_out_after_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == edf_pkg::S_SELECT |=> o_valid)
        else $error("no result after select");
    a_no_take_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == edf_pkg::S_SELECT |-> o_stall && !o_cmd.load)
        else $error("item taken while busy");
    a_sel_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.select |-> o_cmd.step)
        else $error("select outside step");

endmodule
`default_nettype wire

### hdl/edf_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// EDF scheduler datapath
// Sorted shift queue, running task, clock and counters.
// ----------------------------------------------------------------------------
module edf_dp #(
    parameter int QUEUE_DEPTH = edf_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = edf_pkg::ID_BITS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  edf_pkg::t_cmd               i_cmd,
    output edf_pkg::t_stat              o_st,
    input  wire [1:0]                   i_mode,
    input  wire [7:0]                   i_task_id,
    input  wire                         i_realtime_req,
    input  wire [edf_pkg::REL_W-1:0]    i_start_ms,
    input  wire [edf_pkg::REL_W-1:0]    i_deadline_ms,
    output logic [2:0]                  o_status,
    output logic [7:0]                  o_selected_id,
    output logic [edf_pkg::REL_W-1:0]   o_earliest_start_ms,
    output logic [edf_pkg::CNT_W-1:0]   o_met_count,
    output logic [edf_pkg::CNT_W-1:0]   o_miss_count,
    output logic [edf_pkg::CLK_W-1:0]   o_now_ms
);

    localparam int RW = edf_pkg::REL_W;
    localparam int KW = edf_pkg::KEY_W;
    localparam int CW = edf_pkg::CLK_W;
    localparam int NW = edf_pkg::CNT_W;
    localparam int IW = ID_BITS + 1;

    logic [QUEUE_DEPTH-1:0] r_vld, n_vld;
    logic [IW-1:0]          r_id  [QUEUE_DEPTH];
    logic [RW-1:0]          r_rel [QUEUE_DEPTH];
    logic [KW-1:0]          r_key [QUEUE_DEPTH];
    logic [IW-1:0]          n_id  [QUEUE_DEPTH];
    logic [RW-1:0]          n_rel [QUEUE_DEPTH];
    logic [KW-1:0]          n_key [QUEUE_DEPTH];

    logic [1:0]    r_mode;
    logic [IW-1:0] r_nid;
    logic [KW-1:0] r_nkey;
    logic [RW-1:0] r_nrel;
    logic          r_run_vld;
    logic [IW-1:0] r_run_id;
    logic [KW-1:0] r_run_key;
    logic          r_pend;
    logic [CW-1:0] r_clk;
    logic [NW-1:0] r_met, r_miss;
    logic [2:0]    r_status;
    logic [7:0]    r_sel;
    logic [RW-1:0] r_early;

    logic [ID_BITS-1:0] new_id;

    // Insert staging: what the step phase inserts.
    logic          ins_en;
    logic [IW-1:0] ins_id;
    logic [KW-1:0] ins_key;
    logic [RW-1:0] ins_rel;
    logic          full;
    logic [QUEUE_DEPTH-1:0] ahead, rdy, first;
    logic [QUEUE_DEPTH-1:0] vld_i;
    logic          any_rdy;
    logic [RW-1:0] min_rel;

    assign full   = r_vld[QUEUE_DEPTH-1];
    assign new_id = ID_BITS'(i_task_id);

    always_comb begin
        ins_en  = 1'b0;
        ins_id  = r_nid;
        ins_key = r_nkey;
        ins_rel = r_nrel;
        case (r_mode)
            edf_pkg::MODE_CREATE: ins_en = !full;
            edf_pkg::MODE_YIELD: begin
                ins_en  = r_run_vld && !full;
                ins_id  = r_run_id;
                ins_key = r_run_key;
                ins_rel = '0;
            end
            default: ins_en = 1'b0;
        endcase
    end

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (r_id[i][IW-1]) begin
                ahead[i] = r_vld[i] && (!ins_id[IW-1] || r_key[i] < ins_key);
            end else begin
                ahead[i] = r_vld[i] && !ins_id[IW-1];
            end
        end
    end

    // Queue after any insert, used by the select in the same step.
    logic [IW-1:0] a_id  [QUEUE_DEPTH];
    logic [RW-1:0] a_rel [QUEUE_DEPTH];
    logic [KW-1:0] a_key [QUEUE_DEPTH];

    always_comb begin
        vld_i = r_vld;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            a_id[i]  = r_id[i];
            a_rel[i] = r_rel[i];
            a_key[i] = r_key[i];
            if (ins_en && !ahead[i]) begin
                if (i == 0 || ahead[i-1]) begin
                    a_id[i]  = ins_id;
                    a_rel[i] = ins_rel;
                    a_key[i] = ins_key;
                end else begin
                    a_id[i]  = r_id[i-1];
                    a_rel[i] = r_rel[i-1];
                    a_key[i] = r_key[i-1];
                end
            end
        end
        if (ins_en) vld_i = {r_vld[QUEUE_DEPTH-2:0], 1'b1};
    end

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            rdy[i] = vld_i[i] && (!a_id[i][IW-1] || {1'b0, a_rel[i]} <= r_clk);
        end
        first   = rdy & (~rdy + 1'b1);
        any_rdy = |rdy;
        min_rel = '1;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (vld_i[i] && a_rel[i] < min_rel) min_rel = a_rel[i];
        end
    end

    logic [IW-1:0] pick_id;
    logic [KW-1:0] pick_key;
    logic          removing;
    logic [QUEUE_DEPTH-1:0] below;

    always_comb begin
        pick_id  = '0;
        pick_key = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (first[i]) begin
                pick_id  = a_id[i];
                pick_key = a_key[i];
            end
        end
        removing = i_cmd.select && any_rdy;
        below    = first - 1'b1;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (removing && !below[i] && i < QUEUE_DEPTH - 1) begin
                n_id[i]  = a_id[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                n_rel[i] = a_rel[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                n_key[i] = a_key[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            end else begin
                n_id[i]  = a_id[i];
                n_rel[i] = a_rel[i];
                n_key[i] = a_key[i];
            end
        end
        n_vld = removing ? (vld_i >> 1) : vld_i;
    end

    logic met_hit;
    assign met_hit = r_run_key >= r_clk;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_nid  <= i_realtime_req ? {1'b1, new_id}
                                     : {1'b0, new_id};
            r_nkey <= i_realtime_req ? {1'b0, i_start_ms} + {1'b0, i_deadline_ms} : '0;
            r_nrel <= i_realtime_req ? i_start_ms : '0;
        end
        if (i_cmd.step) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_id[i]  <= n_id[i];
                r_rel[i] <= n_rel[i];
                r_key[i] <= n_key[i];
            end
        end
        if (i_cmd.emit) begin
            r_status <= edf_pkg::ST_NONE;
            r_sel    <= '0;
            r_early  <= '0;
            if ((r_mode == edf_pkg::MODE_CREATE || r_mode == edf_pkg::MODE_YIELD)
                && full && !(r_mode == edf_pkg::MODE_YIELD && !r_run_vld)) begin
                r_status <= edf_pkg::ST_FULL;
            end else if (i_cmd.select) begin
                if (any_rdy) begin
                    r_status <= edf_pkg::ST_SEL;
                    r_sel    <= 8'(pick_id[ID_BITS-1:0]);
                end else if (r_mode != edf_pkg::MODE_TICK) begin
                    if (vld_i[0]) begin
                        r_status <= edf_pkg::ST_WAIT;
                        r_early  <= min_rel;
                    end else begin
                        r_status <= edf_pkg::ST_EMPTY;
                    end
                end
            end
        end
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_run_vld <= 1'b0;
            r_run_id  <= '0;
            r_run_key <= '0;
            r_pend    <= 1'b0;
            r_clk     <= '0;
            r_met     <= '0;
            r_miss    <= '0;
        end else begin
            if (i_cmd.load && i_mode == edf_pkg::MODE_TICK && r_clk != '1) begin
                r_clk <= r_clk + 1'b1;
            end
            if (i_cmd.step) begin
                r_vld <= n_vld;
                if (r_mode == edf_pkg::MODE_FINISH && r_run_vld && r_run_id[IW-1]) begin
                    if (met_hit) begin
                        if (r_met != '1) r_met <= r_met + 1'b1;
                    end else if (r_miss != '1) begin
                        r_miss <= r_miss + 1'b1;
                    end
                end
                if (i_cmd.select) begin
                    r_run_vld <= any_rdy;
                    r_pend    <= !any_rdy && vld_i[0];
                    if (any_rdy) begin
                        r_run_id  <= pick_id;
                        r_run_key <= pick_key;
                    end
                end
            end
        end
    end

    assign o_st.mode    = r_mode;
    assign o_st.full    = (r_mode == edf_pkg::MODE_YIELD) && full && r_run_vld;
    assign o_st.pending = r_pend;

    assign o_status            = r_status;
    assign o_selected_id       = r_sel;
    assign o_earliest_start_ms = r_early;
    assign o_met_count         = r_met;
    assign o_miss_count        = r_miss;
    assign o_now_ms            = r_clk;

    a_run_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[QUEUE_DEPTH-1] |-> r_vld[0])
        else $error("valid bits not a run from slot zero");
    a_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_vld[0])
        else $error("select pending on empty queue");
    a_sel_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.select && any_rdy |=> r_run_vld && !r_pend)
        else $error("selected task not running");

endmodule
`default_nettype wire

### hdl/edf_task_scheduler_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// EDF task scheduler unit
// Earliest-deadline-first scheduler with a millisecond clock and sorted queue.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// in       input      i_valid / o_stall  mode, task_id, realtime_req, start, deadline
// out      output     o_valid / i_stall  status, selected_id, earliest, counts, now
//
// An item is captured first and then goes through the queue step,
// where the insert and the select go through the shift queue together.
// The next item is taken in the cycle its predecessor's result is taken.
// Reset empties the queue and clears the clock, counters and running task.
// A stalled result holds the block; no item is taken until it leaves.
// ----------------------------------------------------------------------------
module edf_task_scheduler_unit #(
    parameter int QUEUE_DEPTH = edf_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = edf_pkg::ID_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire [1:0]                        i_mode,
    input  wire [7:0]                        i_task_id,
    input  wire                              i_realtime_req,
    input  wire [edf_pkg::REL_W-1:0]         i_start_ms,
    input  wire [edf_pkg::REL_W-1:0]         i_deadline_ms,
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic [2:0]                       o_status,
    output logic [7:0]                       o_selected_id,
    output logic [edf_pkg::REL_W-1:0]        o_earliest_start_ms,
    output logic [edf_pkg::CNT_W-1:0]        o_met_count,
    output logic [edf_pkg::CNT_W-1:0]        o_miss_count,
    output logic [edf_pkg::CLK_W-1:0]        o_now_ms
);

    edf_pkg::t_cmd  cmd;
    edf_pkg::t_stat st;

    edf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    edf_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_st                (st),
        .i_mode              (i_mode),
        .i_task_id           (i_task_id),
        .i_realtime_req      (i_realtime_req),
        .i_start_ms          (i_start_ms),
        .i_deadline_ms       (i_deadline_ms),
        .o_status            (o_status),
        .o_selected_id       (o_selected_id),
        .o_earliest_start_ms (o_earliest_start_ms),
        .o_met_count         (o_met_count),
        .o_miss_count        (o_miss_count),
        .o_now_ms            (o_now_ms)
    );

endmodule
`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDF task scheduler unit testbench
// Directed and random ticks, creates, yields and finishes are sent to the
// scheduler. A behavioral scheduler predicts each result, and a checker
// compares each result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  sel_id;
        logic [29:0] earliest;
        logic [15:0] met;
        logic [15:0] miss;
        logic [30:0] now;
    } t_sched_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_mode;
    logic [7:0]  i_task_id;
    logic        i_realtime_req;
    logic [29:0] i_start_ms;
    logic [29:0] i_deadline_ms;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_status;
    logic [7:0]  o_selected_id;
    logic [29:0] o_earliest_start_ms;
    logic [15:0] o_met_count;
    logic [15:0] o_miss_count;
    logic [30:0] o_now_ms;

    edf_task_scheduler_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_mode(i_mode), .i_task_id(i_task_id), .i_realtime_req(i_realtime_req),
        .i_start_ms(i_start_ms), .i_deadline_ms(i_deadline_ms),
        .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
        .o_selected_id(o_selected_id), .o_earliest_start_ms(o_earliest_start_ms),
        .o_met_count(o_met_count), .o_miss_count(o_miss_count), .o_now_ms(o_now_ms)
    );

    t_sched_result expected_results[$];
    int error_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int cycle_count = 0;

    logic [30:0] sched_clock;
    int          queue_len;
    logic [8:0]  queue_ident[DEPTH];
    logic [29:0] queue_release[DEPTH];
    logic [30:0] queue_key[DEPTH];
    logic        run_valid;
    logic [8:0]  run_ident;
    logic [30:0] run_key;
    logic        select_waiting;
    logic [15:0] met_total;
    logic [15:0] miss_total;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    function automatic bit queue_insert(input logic [8:0] ident, input logic [30:0] key,
                                        input logic [29:0] rel);
        int pos;
        bit q_rt;
        bit ahead;
        if (queue_len >= DEPTH) return 1'b0;
        pos = 0;
        while (pos < queue_len) begin
            q_rt = queue_ident[pos][8];
            ahead = q_rt ? (!ident[8] || queue_key[pos] < key) : !ident[8];
            if (!ahead) break;
            pos++;
        end
        for (int i = queue_len; i > pos; i--) begin
            queue_ident[i] = queue_ident[i-1];
            queue_release[i] = queue_release[i-1];
            queue_key[i] = queue_key[i-1];
        end
        queue_ident[pos] = ident;
        queue_key[pos] = key;
        queue_release[pos] = rel;
        queue_len++;
        return 1'b1;
    endfunction

    function automatic void select_next(inout t_sched_result r);
        logic [29:0] min_rel;
        bit have_min;
        have_min = 1'b0;
        min_rel = '0;
        run_valid = 1'b0;
        for (int i = 0; i < queue_len; i++) begin
            if (!queue_ident[i][8] || {1'b0, queue_release[i]} <= sched_clock) begin
                run_valid = 1'b1;
                run_ident = queue_ident[i];
                run_key = queue_key[i];
                for (int j = i; j < queue_len - 1; j++) begin
                    queue_ident[j] = queue_ident[j+1];
                    queue_release[j] = queue_release[j+1];
                    queue_key[j] = queue_key[j+1];
                end
                queue_len--;
                select_waiting = 1'b0;
                r.status = edf_pkg::ST_SEL;
                r.sel_id = run_ident[7:0];
                return;
            end
            if (!have_min || queue_release[i] < min_rel) begin
                min_rel = queue_release[i];
                have_min = 1'b1;
            end
        end
        if (queue_len == 0) begin
            select_waiting = 1'b0;
            r.status = edf_pkg::ST_EMPTY;
            return;
        end
        select_waiting = 1'b1;
        r.status = edf_pkg::ST_WAIT;
        r.earliest = min_rel;
    endfunction

    function automatic t_sched_result predict_scheduler(input logic [1:0] mode,
                                                        input logic [7:0] id,
                                                        input logic rt,
                                                        input logic [29:0] start,
                                                        input logic [29:0] dl);
        t_sched_result r;
        bit ok;
        r = '0;
        if (mode == edf_pkg::MODE_TICK) begin
            if (sched_clock != 31'h7FFF_FFFF) sched_clock = sched_clock + 1;
            if (select_waiting) begin
                select_next(r);
                if (r.status != edf_pkg::ST_SEL) begin
                    r.status = edf_pkg::ST_NONE;
                    r.earliest = '0;
                end
            end
        end else if (mode == edf_pkg::MODE_CREATE) begin
            ok = rt ? queue_insert({1'b1, id}, {1'b0, start} + {1'b0, dl}, start)
                    : queue_insert({1'b0, id}, '0, '0);
            r.status = ok ? edf_pkg::ST_NONE : edf_pkg::ST_FULL;
        end else if (mode == edf_pkg::MODE_YIELD) begin
            if (run_valid && !queue_insert(run_ident, run_key, '0))
                r.status = edf_pkg::ST_FULL;
            else select_next(r);
        end else begin
            if (run_valid && run_ident[8]) begin
                if (run_key >= sched_clock) begin
                    if (met_total != 16'hFFFF) met_total++;
                end else if (miss_total != 16'hFFFF) begin
                    miss_total++;
                end
            end
            run_valid = 1'b0;
            select_next(r);
        end
        r.met = met_total;
        r.miss = miss_total;
        r.now = sched_clock;
        return r;
    endfunction

    task automatic send_item(input logic [1:0] mode, input logic [7:0] id,
                             input logic rt, input logic [29:0] start,
                             input logic [29:0] dl);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_mode = mode;
        i_task_id = id;
        i_realtime_req = rt;
        i_start_ms = start;
        i_deadline_ms = dl;
        do @(posedge i_clk); while (o_stall);
        expected_results.push_back(predict_scheduler(mode, id, rt, start, dl));
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid = 1'b0;
        while (expected_results.size() > 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_sched_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with no item outstanding");
                error_count++;
            end else begin
                e = expected_results.pop_front();
                if (o_status !== e.status) begin
                    $error("status expected %0d got %0d", e.status, o_status);
                    error_count++;
                end
                if (o_selected_id !== e.sel_id) begin
                    $error("selected_id expected %0d got %0d", e.sel_id, o_selected_id);
                    error_count++;
                end
                if (o_earliest_start_ms !== e.earliest) begin
                    $error("earliest_start_ms expected %0d got %0d", e.earliest,
                           o_earliest_start_ms);
                    error_count++;
                end
                if (o_met_count !== e.met) begin
                    $error("met_count expected %0d got %0d", e.met, o_met_count);
                    error_count++;
                end
                if (o_miss_count !== e.miss) begin
                    $error("miss_count expected %0d got %0d", e.miss, o_miss_count);
                    error_count++;
                end
                if (o_now_ms !== e.now) begin
                    $error("now_ms expected %0d got %0d", e.now, o_now_ms);
                    error_count++;
                end
            end
        end
    end

    task automatic test_empty_queue();
        send_item(edf_pkg::MODE_FINISH, 8'h00, 1'b0, '0, '0);
        send_item(edf_pkg::MODE_YIELD, 8'h00, 1'b0, '0, '0);
        send_item(edf_pkg::MODE_TICK, 8'h00, 1'b0, '0, '0);
    endtask

    task automatic test_ordering();
        send_item(edf_pkg::MODE_CREATE, 8'h00, 1'b0, '0, '0);
        send_item(edf_pkg::MODE_CREATE, 8'hFF, 1'b0, '1, '1);
        send_item(edf_pkg::MODE_CREATE, 8'h11, 1'b1, 30'd0, 30'd5);
        send_item(edf_pkg::MODE_CREATE, 8'h22, 1'b1, 30'd1, 30'd4);
        send_item(edf_pkg::MODE_CREATE, 8'h33, 1'b1, 30'd0, 30'd0);
        send_item(edf_pkg::MODE_FINISH, 8'h00, 1'b0, '0, '0);
        send_item(edf_pkg::MODE_FINISH, 8'h00, 1'b0, '0, '0);
        send_item(edf_pkg::MODE_YIELD, 8'h00, 1'b0, '0, '0);
        repeat (3) send_item(edf_pkg::MODE_TICK, 8'h00, 1'b0, '0, '0);
        repeat (5) send_item(edf_pkg::MODE_FINISH, 8'h00, 1'b0, '0, '0);
    endtask

    task automatic test_release_wait();
        send_item(edf_pkg::MODE_CREATE, 8'h44, 1'b1, sched_clock[29:0] + 30'd3, 30'd2);
        send_item(edf_pkg::MODE_CREATE, 8'h55, 1'b1, sched_clock[29:0] + 30'd2, 30'd9);
        send_item(edf_pkg::MODE_FINISH, 8'h00, 1'b0, '0, '0);
        send_item(edf_pkg::MODE_CREATE, 8'h66, 1'b1, sched_clock[29:0] + 30'd9, 30'd0);
        repeat (4) send_item(edf_pkg::MODE_TICK, 8'h00, 1'b0, '0, '0);
        repeat (3) send_item(edf_pkg::MODE_FINISH, 8'h00, 1'b0, '0, '0);
        repeat (10) send_item(edf_pkg::MODE_TICK, 8'h00, 1'b0, '0, '0);
        send_item(edf_pkg::MODE_FINISH, 8'h00, 1'b0, '0, '0);
    endtask

    task automatic test_full_queue();
        send_item(edf_pkg::MODE_CREATE, 8'hA5, 1'b0, '0, '0);
        send_item(edf_pkg::MODE_FINISH, 8'h00, 1'b0, '0, '0);
        for (int i = 0; i < DEPTH + 1; i++)
            send_item(edf_pkg::MODE_CREATE, 8'(i), 1'(i % 2), sched_clock[29:0], 30'(i));
        send_item(edf_pkg::MODE_YIELD, 8'h00, 1'b0, '0, '0);
        for (int i = 0; i < DEPTH + 2; i++)
            send_item(edf_pkg::MODE_FINISH, 8'h00, 1'b0, '0, '0);
    endtask

    task automatic test_random(input int count);
        int pick;
        logic [29:0] start;
        logic [29:0] dl;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            start = sched_clock[29:0] + 30'($urandom_range(12));
            if ($urandom_range(3) == 0) start = start - 30'($urandom_range(20));
            dl = ($urandom_range(9) == 0) ? 30'($urandom) : 30'($urandom_range(40));
            if (pick < 35)
                send_item(edf_pkg::MODE_CREATE, 8'($urandom), 1'($urandom), start, dl);
            else if (pick < 65)
                send_item(edf_pkg::MODE_TICK, 8'($urandom), 1'($urandom), 30'($urandom),
                          30'($urandom));
            else if (pick < 80)
                send_item(edf_pkg::MODE_YIELD, 8'($urandom), 1'($urandom), 30'($urandom),
                          30'($urandom));
            else
                send_item(edf_pkg::MODE_FINISH, 8'($urandom), 1'($urandom), 30'($urandom),
                          30'($urandom));
        end
    endtask

    task automatic test_far_release();
        for (int i = 0; i < 4; i++)
            send_item(edf_pkg::MODE_CREATE, 8'($urandom), 1'b1,
                      30'($urandom) | 30'h2000_0000, 30'($urandom));
        send_item(edf_pkg::MODE_FINISH, 8'h00, 1'b0, '0, '0);
        send_item(edf_pkg::MODE_TICK, 8'h00, 1'b0, '0, '0);
        send_item(edf_pkg::MODE_CREATE, 8'h7E, 1'b0, '0, '0);
        send_item(edf_pkg::MODE_TICK, 8'h00, 1'b0, '0, '0);
        send_item(edf_pkg::MODE_YIELD, 8'h00, 1'b0, '0, '0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_mode = edf_pkg::MODE_TICK;
        i_task_id = '0;
        i_realtime_req = 1'b0;
        i_start_ms = '0;
        i_deadline_ms = '0;
        sched_clock = '0;
        queue_len = 0;
        run_valid = 1'b0;
        run_ident = '0;
        run_key = '0;
        select_waiting = 1'b0;
        met_total = '0;
        miss_total = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_queue();
        test_ordering();
        test_release_wait();
        test_full_queue();
        wait_idle();

        idle_pct = 0;  stall_pct = 0;  test_random(320);
        idle_pct = 54; stall_pct = 0;  test_random(320);
        wait_idle();
        idle_pct = 0;  stall_pct = 54; test_random(320);
        idle_pct = 33; stall_pct = 33; test_random(320);
        test_far_release();

        wait_idle();
        repeat (10) @(negedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            if (expected_results.size() != 0)
                $error("%0d results never arrived", expected_results.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
